// File: sv/line_editor_insert_overwrite_assert.svh
// ----------------------------------------------------------------------------
// Line editor assertion macros
// Implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_INSERT_OVERWRITE_ASSERT_SVH
`define LINE_EDITOR_INSERT_OVERWRITE_ASSERT_SVH

// same-cycle implication
`define LEIO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LEIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/leio_pkg.sv
// ----------------------------------------------------------------------------
// Line editor package
// Key codes, result kinds, cell control type and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package leio_pkg;

    localparam int MAX_LINE_DEF = 64;
    localparam int LEN_W        = 7;
    localparam int POS_W        = 8;
    localparam int CH_W         = 8;

    localparam logic [CH_W-1:0] KEY_NONE   = 8'd0;
    localparam logic [CH_W-1:0] KEY_STOP   = 8'd3;
    localparam logic [CH_W-1:0] KEY_ENTER  = 8'd13;
    localparam logic [CH_W-1:0] KEY_LF     = 8'd10;
    localparam logic [CH_W-1:0] KEY_LEFT   = 8'd157;
    localparam logic [CH_W-1:0] KEY_UP     = 8'd145;
    localparam logic [CH_W-1:0] KEY_RIGHT  = 8'd29;
    localparam logic [CH_W-1:0] KEY_DOWN   = 8'd17;
    localparam logic [CH_W-1:0] KEY_INS    = 8'd148;
    localparam logic [CH_W-1:0] KEY_DEL    = 8'd20;
    localparam logic [CH_W-1:0] KEY_BS     = 8'd8;
    localparam logic [CH_W-1:0] KEY_RUBOUT = 8'd127;
    localparam logic [CH_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [CH_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [CH_W-1:0] CH_BANG    = 8'd33;
    localparam logic [CH_W-1:0] CH_BAR     = 8'd124;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    localparam logic [1:0] CFG_REQ_MAX = 2'd0;
    localparam logic [1:0] CFG_SCR_W   = 2'd1;
    localparam logic [1:0] CFG_START   = 2'd2;

    localparam logic [6:0] REQ_MAX_RST = 7'd40;
    localparam logic [7:0] SCR_W_RST   = 8'd40;
    localparam logic [7:0] START_RST   = 8'd0;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_INS,
        CELL_PUT
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
        logic [CH_W-1:0]   ch;
    } t_cell_ctl;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: sv/line_editor_insert_overwrite.sv
// ----------------------------------------------------------------------------
// Line editor with insert and overwrite modes
// Edits one line held in a row of character cells; emits it on enter.
// ----------------------------------------------------------------------------
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+--------------------------------------
//  key in   | i_valid  | o_stall  | i_key
//  result   | o_valid  | i_stall  | o_kind o_char_out o_length o_cursor
//           |          |          | o_insert_on o_last
//  config   | i_cfg_we | -        | i_cfg_idx i_cfg_data
//
//  On an edit key all cells shift or load in parallel.
//  On enter the row shifts left one cell a cycle, while the output register
//  is free or draining, giving one result per character (up to MAX_LINE).
//  A key is taken only while the output register is free or draining.
//  Reset clears length and cursor, sets insert mode; cell data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_editor_insert_overwrite_assert.svh"

module line_editor_insert_overwrite
    import leio_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [CH_W-1:0]  i_key,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic      [1:0]       o_kind,
    output logic      [CH_W-1:0]  o_char_out,
    output logic      [LEN_W-1:0] o_length,
    output logic      [LEN_W-1:0] o_cursor,
    output logic                  o_insert_on,
    output logic                  o_last,
    input  wire logic             i_stall,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [7:0]       i_cfg_data
);

    localparam int LW = $clog2(MAX_LINE + 1);

    logic [6:0]    r_req_max;
    logic [7:0]    r_scr_w;
    logic [7:0]    r_start;

    t_state        r_state;
    t_state        n_state;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] n_cur;
    logic          r_ins;
    logic          n_ins;
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] n_cnt;

    logic             r_ov;
    logic             n_ov;
    logic [1:0]       r_kind;
    logic [1:0]       n_kind;
    logic [CH_W-1:0]  r_char;
    logic [CH_W-1:0]  n_char;
    logic [LEN_W-1:0] r_olen;
    logic [LEN_W-1:0] n_olen;
    logic [LEN_W-1:0] r_ocur;
    logic [LEN_W-1:0] n_ocur;
    logic             r_oins;
    logic             n_oins;
    logic             r_olast;
    logic             n_olast;

    t_cell_ctl        w_ctl;
    logic [CH_W-1:0]  w_data [MAX_LINE];

    logic       out_free;
    logic       accept;
    logic [7:0] avail;
    logic [7:0] lim_a;
    logic [7:0] lim_b;
    logic [7:0] limit;
    logic       is_print;
    logic [CH_W-1:0] put_ch;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_max <= REQ_MAX_RST;
            r_scr_w   <= SCR_W_RST;
            r_start   <= START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REQ_MAX: r_req_max <= i_cfg_data[6:0];
                CFG_SCR_W:   r_scr_w   <= i_cfg_data;
                CFG_START:   r_start   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // ---- line limit ----
    always_comb begin
        avail = (r_start < r_scr_w) ? (r_scr_w - r_start) : 8'd0;
        lim_a = ({1'b0, r_req_max} < avail) ? {1'b0, r_req_max} : avail;
        lim_b = (lim_a > 8'(MAX_LINE)) ? 8'(MAX_LINE) : lim_a;
        limit = (lim_b == 8'd0) ? 8'd1 : lim_b;
    end

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;
    assign is_print = (i_key >= PRINT_LO) && (i_key <= PRINT_HI);
    assign put_ch   = (i_key == CH_BANG) ? CH_BAR : i_key;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_key == KEY_ENTER || i_key == KEY_LF)
                        && r_len != '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && r_cnt == LW'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- datapath and results ----
    always_comb begin
        n_len   = r_len;
        n_cur   = r_cur;
        n_ins   = r_ins;
        n_cnt   = r_cnt;
        n_ov    = r_ov && i_stall;
        n_kind  = r_kind;
        n_char  = r_char;
        n_olen  = r_olen;
        n_ocur  = r_ocur;
        n_oins  = r_oins;
        n_olast = r_olast;
        w_ctl.op  = CELL_HOLD;
        w_ctl.pos = POS_W'(r_cur);
        w_ctl.ch  = put_ch;

        case (r_state)
            S_IDLE: begin
                if (accept && i_key != KEY_NONE) begin
                    n_kind  = KIND_UPDATE;
                    n_char  = '0;
                    n_olast = 1'b1;
                    n_ov    = 1'b1;
                    if (i_key == KEY_STOP) begin
                        n_len  = '0;
                        n_cur  = '0;
                        n_ins  = 1'b1;
                        n_kind = KIND_CANCEL;
                    end else if (i_key == KEY_ENTER || i_key == KEY_LF) begin
                        if (r_len == '0) begin
                            n_kind = KIND_EMPTY;
                            n_cur  = '0;
                            n_ins  = 1'b1;
                        end else begin
                            n_ov  = r_ov && i_stall;
                            n_cnt = r_len;
                        end
                    end else if (i_key == KEY_LEFT || i_key == KEY_UP) begin
                        if (r_cur != '0) n_cur = r_cur - LW'(1);
                    end else if (i_key == KEY_RIGHT || i_key == KEY_DOWN) begin
                        if (r_cur < r_len) n_cur = r_cur + LW'(1);
                    end else if (i_key == KEY_INS) begin
                        n_ins = !r_ins;
                    end else if (i_key == KEY_DEL || i_key == KEY_BS
                            || i_key == KEY_RUBOUT) begin
                        if (r_cur != '0 && r_len != '0) begin
                            w_ctl.op  = CELL_SHL;
                            w_ctl.pos = POS_W'(r_cur - LW'(1));
                            n_cur     = r_cur - LW'(1);
                            n_len     = r_len - LW'(1);
                        end
                    end else if (is_print) begin
                        if (8'(r_len) < limit) begin
                            if (r_ins && r_cur < r_len) begin
                                w_ctl.op = CELL_INS;
                                n_len    = r_len + LW'(1);
                            end else begin
                                w_ctl.op = CELL_PUT;
                                if (r_cur == r_len) n_len = r_len + LW'(1);
                            end
                            n_cur = r_cur + LW'(1);
                        end
                    end
                    n_olen = LEN_W'(n_len);
                    n_ocur = LEN_W'(n_cur);
                    // empty-line result shows the mode from before the clear
                    n_oins = (n_kind == KIND_EMPTY) ? r_ins : n_ins;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    w_ctl.op  = CELL_SHL;
                    w_ctl.pos = '0;
                    n_ov      = 1'b1;
                    n_kind    = KIND_CHAR;
                    n_char    = w_data[0];
                    n_olen    = LEN_W'(r_len);
                    n_ocur    = LEN_W'(r_cur);
                    n_oins    = r_ins;
                    n_olast   = (r_cnt == LW'(1));
                    n_cnt     = r_cnt - LW'(1);
                    if (r_cnt == LW'(1)) begin
                        n_len = '0;
                        n_cur = '0;
                        n_ins = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_cur   <= '0;
            r_ins   <= 1'b1;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cur   <= n_cur;
            r_ins   <= n_ins;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_olen  <= n_olen;
        r_ocur  <= n_ocur;
        r_oins  <= n_oins;
        r_olast <= n_olast;
    end

    // ---- cell row ----
    for (genvar g = 0; g < MAX_LINE; g++) begin : g_cell
        logic [CH_W-1:0] w_left;
        logic [CH_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == MAX_LINE - 1) begin : g_final
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        leio_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign o_valid     = r_ov;
    assign o_kind      = r_kind;
    assign o_char_out  = r_char;
    assign o_length    = r_olen;
    assign o_cursor    = r_ocur;
    assign o_insert_on = r_oins;
    assign o_last      = r_olast;

    // ---- checks ----
    `LEIO_ASSERT_NOW(a_cur_in_line, i_clk, i_rst_n, 1'b1, r_cur <= r_len, "cursor past end")
    `LEIO_ASSERT_NOW(a_len_cap, i_clk, i_rst_n, 1'b1, r_len <= LW'(MAX_LINE), "length over cap")
    `LEIO_ASSERT_NOW(a_emit_blocks, i_clk, i_rst_n, r_state == S_EMIT, o_stall, "key taken in emit")
    `LEIO_ASSERT_NEXT(a_stop_result, i_clk, i_rst_n, accept && i_key == KEY_STOP, o_valid && o_kind == KIND_CANCEL && o_last && o_length == '0, "stop result wrong")

endmodule

`default_nettype wire

// File: sv/leio_cell.sv
// ----------------------------------------------------------------------------
// Line editor character cell
// Holds one character; shifts from a neighbor or loads a new key per command.
// ----------------------------------------------------------------------------
`default_nettype none

module leio_cell
    import leio_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CH_W-1:0]  i_left,
    input  wire logic [CH_W-1:0]  i_right,
    output logic      [CH_W-1:0]  o_data
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [CH_W-1:0] r_data;
    logic [CH_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_SHL: begin
                if (MY_POS >= i_ctl.pos) n_data = i_right;
            end
            CELL_INS: begin
                if (MY_POS > i_ctl.pos) begin
                    n_data = i_left;
                end else if (MY_POS == i_ctl.pos) begin
                    n_data = i_ctl.ch;
                end
            end
            CELL_PUT: begin
                if (MY_POS == i_ctl.pos) n_data = i_ctl.ch;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: dv/line_editor_insert_overwrite_chk.sv
// ----------------------------------------------------------------------------
// Line editor checker
// Watches the key, result and register ports. It keeps its own copy of the
// line, cursor, mode and limit registers, and works out the results that each
// accepted key request should give. Each accepted result is compared field
// by field with the oldest one still due.
// ----------------------------------------------------------------------------
module line_editor_insert_overwrite_chk
    import leio_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_key_valid,
    input  logic             i_key_stall,
    input  logic [CH_W-1:0]  i_key,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  logic [1:0]       i_kind,
    input  logic [CH_W-1:0]  i_char,
    input  logic [LEN_W-1:0] i_length,
    input  logic [LEN_W-1:0] i_cursor,
    input  logic             i_insert_on,
    input  logic             i_last,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    output int               o_fail_cnt,
    output int               o_due_cnt,
    output int               o_key_cnt,
    output int               o_res_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CH_W-1:0]  ch;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cur;
        logic             ins;
        logic             last;
    } t_line_res;

    t_line_res       line_results_due[$];
    logic [CH_W-1:0] line_chars [MAX_LINE_DEF];
    int              line_len;
    int              cur_pos;
    logic            ins_mode;
    logic [6:0]      req_max;
    logic [7:0]      scr_w;
    logic [7:0]      start_col;
    int              fails;
    int              keys_taken;
    int              results_seen;

    function automatic int line_limit();
        int lim;
        int avail;
        lim = int'(req_max);
        if (start_col < scr_w) begin
            avail = int'(scr_w) - int'(start_col);
            if (avail < lim) lim = avail;
        end else begin
            lim = 0;
        end
        if (lim > MAX_LINE_DEF) lim = MAX_LINE_DEF;
        if (lim == 0) lim = 1;
        return lim;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic [CH_W-1:0] ch, logic last);
        t_line_res r;
        r.kind = kind;
        r.ch   = ch;
        r.len  = line_len[LEN_W-1:0];
        r.cur  = cur_pos[LEN_W-1:0];
        r.ins  = ins_mode;
        r.last = last;
        line_results_due.push_back(r);
    endfunction

    function automatic void clear_line();
        line_len = 0;
        cur_pos  = 0;
        ins_mode = 1'b1;
    endfunction

    function automatic void edit_line(logic [CH_W-1:0] k);
        logic [CH_W-1:0] ch;
        int              i;
        if (k == KEY_NONE) return;
        if (k == KEY_STOP) begin
            clear_line();
            queue_result(KIND_CANCEL, '0, 1'b1);
            return;
        end
        if (k == KEY_ENTER || k == KEY_LF) begin
            if (line_len == 0) begin
                queue_result(KIND_EMPTY, '0, 1'b1);
            end else begin
                for (i = 0; i < line_len; i++)
                    queue_result(KIND_CHAR, line_chars[i], i + 1 == line_len);
            end
            clear_line();
            return;
        end
        if (k == KEY_LEFT || k == KEY_UP) begin
            if (cur_pos > 0) cur_pos--;
        end else if (k == KEY_RIGHT || k == KEY_DOWN) begin
            if (cur_pos < line_len) cur_pos++;
        end else if (k == KEY_INS) begin
            ins_mode = !ins_mode;
        end else if (k == KEY_DEL || k == KEY_BS || k == KEY_RUBOUT) begin
            if (cur_pos > 0 && line_len > 0) begin
                cur_pos--;
                for (i = cur_pos; i + 1 < line_len; i++)
                    line_chars[i] = line_chars[i + 1];
                line_len--;
            end
        end else if (k >= PRINT_LO && k <= PRINT_HI) begin
            ch = (k == CH_BANG) ? CH_BAR : k;
            // full line drops the key, overwrite mode included
            if (line_len < line_limit()) begin
                if (ins_mode && cur_pos < line_len) begin
                    for (i = line_len; i > cur_pos; i--)
                        line_chars[i] = line_chars[i - 1];
                    line_chars[cur_pos] = ch;
                    line_len++;
                end else begin
                    line_chars[cur_pos] = ch;
                    if (cur_pos == line_len) line_len++;
                end
                cur_pos++;
            end
        end
        queue_result(KIND_UPDATE, '0, 1'b1);
    endfunction

    function automatic void check_result();
        t_line_res got;
        t_line_res want;
        got.kind = i_kind;
        got.ch   = i_char;
        got.len  = i_length;
        got.cur  = i_cursor;
        got.ins  = i_insert_on;
        got.last = i_last;
        results_seen++;
        if (line_results_due.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("Unexpected result %0d: kind %0d char %02h len %0d cur %0d ins %0b last %0b",
                         results_seen, got.kind, got.ch, got.len, got.cur, got.ins, got.last);
            return;
        end
        want = line_results_due.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.len !== want.len ||
            got.cur !== want.cur || got.ins !== want.ins || got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
                $display("Mismatch on result %0d", results_seen);
                $display("  expected kind %0d char %02h len %0d cur %0d ins %0b last %0b",
                         want.kind, want.ch, want.len, want.cur, want.ins, want.last);
                $display("  actual   kind %0d char %02h len %0d cur %0d ins %0b last %0b",
                         got.kind, got.ch, got.len, got.cur, got.ins, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_results_due.delete();
            clear_line();
            req_max   = REQ_MAX_RST;
            scr_w     = SCR_W_RST;
            start_col = START_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REQ_MAX: req_max   = i_cfg_data[6:0];
                    CFG_SCR_W:   scr_w     = i_cfg_data;
                    CFG_START:   start_col = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_key_valid && !i_key_stall) begin
                keys_taken++;
                edit_line(i_key);
            end
            if (i_res_valid && !i_res_stall) check_result();
        end
        o_fail_cnt <= fails;
        o_due_cnt  <= line_results_due.size();
        o_key_cnt  <= keys_taken;
        o_res_cnt  <= results_seen;
    end

endmodule

// File: dv/line_editor_insert_overwrite_tb.sv
// ----------------------------------------------------------------------------
// Line editor testbench
// Drives key requests through the editor: a directed run over every key
// class and corner, then random keystroke streams under several limit
// settings and idling mixes, including a full line emitted while the result
// side holds off. Checking is done by the companion checker module.
// ----------------------------------------------------------------------------
module line_editor_insert_overwrite_tb;
    import leio_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_KEYS     = 50;
    localparam int FILL_KEYS      = 70;
    localparam int N_PHASES       = 8;
    localparam int N_DIRECTED     = 25;

    // requested max, screen width, start column per phase
    localparam int PH_REQ_MAX [N_PHASES] = '{64, 1, 64, 0, 127, 20, 40, 64};
    localparam int PH_SCR_W   [N_PHASES] = '{255, 40, 255, 1, 200, 30, 40, 100};
    localparam int PH_START   [N_PHASES] = '{0, 0, 255, 0, 10, 25, 0, 50};

    localparam logic [CH_W-1:0] DIRECTED_KEYS [N_DIRECTED] = '{
        KEY_NONE, KEY_DEL, KEY_LEFT, KEY_RIGHT, KEY_ENTER,
        8'h41, CH_BANG, PRINT_HI, PRINT_LO, KEY_LEFT,
        KEY_INS, 8'h42, KEY_UP, KEY_UP, KEY_INS,
        8'h43, KEY_DOWN, KEY_BS, KEY_RUBOUT, 8'hFF,
        8'h80, KEY_LF, 8'h44, KEY_STOP, KEY_ENTER
    };

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    logic [CH_W-1:0]  i_key      = '0;
    logic             i_stall    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_idx  = CFG_REQ_MAX;
    logic [7:0]       i_cfg_data = '0;
    logic             o_stall;
    logic             o_valid;
    logic [1:0]       o_kind;
    logic [CH_W-1:0]  o_char_out;
    logic [LEN_W-1:0] o_length;
    logic [LEN_W-1:0] o_cursor;
    logic             o_insert_on;
    logic             o_last;

    int fail_cnt;
    int due_cnt;
    int key_cnt;
    int res_cnt;
    int send_idle   = 0;
    int recv_idle   = 0;
    bit hold_req    = 1'b0;
    int quiet_cycles = 0;

    line_editor_insert_overwrite u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_key       (i_key),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_char_out  (o_char_out),
        .o_length    (o_length),
        .o_cursor    (o_cursor),
        .o_insert_on (o_insert_on),
        .o_last      (o_last),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    line_editor_insert_overwrite_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (i_valid),
        .i_key_stall (o_stall),
        .i_key       (i_key),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_kind      (o_kind),
        .i_char      (o_char_out),
        .i_length    (o_length),
        .i_cursor    (o_cursor),
        .i_insert_on (o_insert_on),
        .i_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_due_cnt   (due_cnt),
        .o_key_cnt   (key_cnt),
        .o_res_cnt   (res_cnt)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall, or a long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("line_editor_insert_overwrite test failed");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 50) return CH_W'($urandom_range(PRINT_LO, PRINT_HI));
        if (r < 54) return CH_BANG;
        if (r < 61) return $urandom_range(1) ? KEY_LEFT : KEY_UP;
        if (r < 68) return $urandom_range(1) ? KEY_RIGHT : KEY_DOWN;
        if (r < 73) return KEY_INS;
        if (r < 81) begin
            case ($urandom_range(2))
                0:       return KEY_DEL;
                1:       return KEY_BS;
                default: return KEY_RUBOUT;
            endcase
        end
        if (r < 86) return $urandom_range(1) ? KEY_ENTER : KEY_LF;
        if (r < 88) return KEY_STOP;
        if (r < 90) return KEY_NONE;
        return CH_W'($urandom);
    endfunction

    task automatic send_key(input logic [CH_W-1:0] k);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key   <= k;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (due_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 8'(value);
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int ph);
        i_valid <= 1'b0;
        wait_drained();
        write_cfg(CFG_REQ_MAX, PH_REQ_MAX[ph]);
        write_cfg(CFG_SCR_W, PH_SCR_W[ph]);
        write_cfg(CFG_START, PH_START[ph]);
        i_cfg_we <= 1'b0;
        case (ph % 4)
            0:       begin send_idle = 0;  recv_idle = 0;  end
            1:       begin send_idle = 46; recv_idle = 0;  end
            2:       begin send_idle = 0;  recv_idle = 46; end
            default: begin send_idle = 36; recv_idle = 36; end
        endcase
        if (ph == 0) begin
            // overfill a full-width line, then emit it into a held-off receiver
            repeat (FILL_KEYS) send_key(CH_W'($urandom_range(PRINT_LO, PRINT_HI)));
            hold_req = 1'b1;
            send_key(KEY_ENTER);
        end
        repeat (PHASE_KEYS) send_key(pick_key());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED_KEYS[n]) send_key(DIRECTED_KEYS[n]);
        for (int ph = 0; ph < N_PHASES; ph++) run_phase(ph);
        i_valid <= 1'b0;
        wait_drained();
        $display("Sent %0d key requests and checked %0d results over %0d limit settings",
                 key_cnt, res_cnt, N_PHASES);
        $display("with idle-free, sender-idle, receiver-stall and mixed traffic");
        if (fail_cnt == 0 && due_cnt == 0) begin
            $display("line_editor_insert_overwrite test passed");
        end else begin
            $display("%0d mismatches, %0d results still due", fail_cnt, due_cnt);
            $display("line_editor_insert_overwrite test failed");
        end
        $finish;
    end

endmodule
